// ===== rtl/vdw_pkg.sv =====
// Shared types and constants of the van der Waals state evaluator.
// Depends on nothing; the FP unit, the sequencer and the top level refer to it by scoped names.
`default_nettype none
package vdw_pkg;

  typedef enum logic [1:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV
  } fop_t;

  typedef struct packed {
    logic        start;
    fop_t        op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } fpu_rsp_t;

  typedef enum logic [3:0] {
    F_IDLE,
    F_PRENORM,
    F_MUL,
    F_DIV,
    F_ALIGN,
    F_ADD,
    F_NORM,
    F_ROUND,
    F_DONE
  } fpu_st_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_M_RECIP,
    S_M_NU1,
    S_P_RT,
    S_P_DIV,
    S_P_AR,
    S_P_ARR,
    S_P_SUB,
    S_T_AR,
    S_T_ARR,
    S_T_ADD,
    S_T_MUL,
    S_T_DIV,
    S_D_RT,
    S_D_Q,
    S_D_NU0,
    S_D_SQ,
    S_D_AW,
    S_D_PS,
    S_D_U,
    S_D_NN,
    S_D_DIF,
    S_D_INV,
    S_OUT
  } seq_st_t;

  localparam logic [1:0] MODE_PRESSURE    = 2'd0;
  localparam logic [1:0] MODE_TEMPERATURE = 2'd1;
  localparam logic [1:0] MODE_DENSITY     = 2'd2;
  localparam logic [1:0] MODE_UNUSED      = 2'd3;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_VOLUME     = 2'd1;
  localparam logic [1:0] STATUS_ITER_LIMIT = 2'd2;

  localparam logic [1:0] CFG_GAS   = 2'd0;
  localparam logic [1:0] CFG_COVOL = 2'd1;
  localparam logic [1:0] CFG_ATTR  = 2'd2;

  localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_TOL  = 64'h3E45_798E_E230_8C3A;
  localparam logic [63:0] QNAN_DEF = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] QNAN_POS = 64'h7FF8_0000_0000_0000;

endpackage
`default_nettype wire

// ===== rtl/vdw_in_if.sv =====
// Input channel of the evaluator: one beat carries a mode and three doubles.
// Standalone; no package needed.
`default_nettype none
interface vdw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] density_in;
  logic [63:0] temperature_in;
  logic [63:0] pressure_in;

  modport source (output valid, mode, density_in, temperature_in, pressure_in,
                  input ready);
  modport sink (input valid, mode, density_in, temperature_in, pressure_in,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/vdw_out_if.sv =====
// Result channel of the evaluator: one beat carries a double and a status.
// Standalone; no package needed.
`default_nettype none
interface vdw_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_out;
  logic [1:0]  status;

  modport source (output valid, value_out, status, input ready);
  modport sink (input valid, value_out, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/vdw_cfg_if.sv =====
// Configuration write channel: register index and 64-bit write data.
// Standalone; no package needed.
`default_nettype none
interface vdw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/vdw_fpu.sv =====
// Shared multi-cycle IEEE double unit: add, subtract, multiply, divide,
// round to nearest even. Uses vdw_pkg for its request, response and states.
`default_nettype none
module vdw_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  vdw_pkg::fpu_req_t req,
  output vdw_pkg::fpu_rsp_t rsp
);

  vdw_pkg::fpu_st_t state_r, state_nxt;
  vdw_pkg::fop_t    op_r;

  logic [10:0] a_exp, b_exp;
  logic [51:0] a_frac, b_frac;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sb_eff, sgn_md;
  logic signed [12:0] a_e, b_e;
  logic [52:0] a_m, b_m;
  logic [63:0] qa, qb;
  logic        spec_hit;
  logic [63:0] spec_val;

  logic               sa_r, sb_r, sgn_r, st_r, sub_r;
  logic signed [12:0] ea_r, eb_r, e_r;
  logic [52:0]        ma_r, mb_r;
  logic [63:0]        sig_r, bsh_r, res_r;
  logic [6:0]         cnt_r;
  logic [105:0]       acc_r;
  logic [54:0]        rem_r;

  // Operand decode at the start beat.
  always_comb begin
    a_exp  = req.a[62:52];
    b_exp  = req.b[62:52];
    a_frac = req.a[51:0];
    b_frac = req.b[51:0];
    a_nan  = (&a_exp) & (|a_frac);
    b_nan  = (&b_exp) & (|b_frac);
    a_inf  = (&a_exp) & ~(|a_frac);
    b_inf  = (&b_exp) & ~(|b_frac);
    a_zero = ~(|req.a[62:0]);
    b_zero = ~(|req.b[62:0]);
    sb_eff = req.b[63] ^ (req.op == vdw_pkg::FOP_SUB);
    sgn_md = req.a[63] ^ req.b[63];
    a_e    = (a_exp == 11'd0) ? -13'sd1022 : $signed({2'b00, a_exp}) - 13'sd1023;
    b_e    = (b_exp == 11'd0) ? -13'sd1022 : $signed({2'b00, b_exp}) - 13'sd1023;
    a_m    = {|a_exp, a_frac};
    b_m    = {|b_exp, b_frac};
    qa     = req.a | 64'h0008_0000_0000_0000;
    qb     = req.b | 64'h0008_0000_0000_0000;
  end

  // NaN, infinity and zero operands are settled without the datapath.
  always_comb begin
    spec_hit = 1'b1;
    spec_val = '0;
    unique case (req.op)
      vdw_pkg::FOP_ADD, vdw_pkg::FOP_SUB: begin
        priority if (a_nan) spec_val = qa;
        else if (b_nan) spec_val = qb;
        else if (a_inf && b_inf && (req.a[63] != sb_eff)) spec_val = vdw_pkg::QNAN_DEF;
        else if (a_inf) spec_val = req.a;
        else if (b_inf) spec_val = {sb_eff, req.b[62:0]};
        else if (a_zero && b_zero) spec_val = {req.a[63] & sb_eff, 63'd0};
        else if (b_zero) spec_val = req.a;
        else if (a_zero) spec_val = {sb_eff, req.b[62:0]};
        else spec_hit = 1'b0;
      end
      vdw_pkg::FOP_MUL: begin
        priority if (a_nan) spec_val = qa;
        else if (b_nan) spec_val = qb;
        else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = vdw_pkg::QNAN_DEF;
        else if (a_inf || b_inf) spec_val = {sgn_md, 11'h7FF, 52'd0};
        else if (a_zero || b_zero) spec_val = {sgn_md, 63'd0};
        else spec_hit = 1'b0;
      end
      vdw_pkg::FOP_DIV: begin
        // A zero divisor never reaches the divider: NaN or zero over zero
        // gives the positive quiet NaN, anything else a signed infinity.
        priority if (b_zero && (a_nan || a_zero)) spec_val = vdw_pkg::QNAN_POS;
        else if (b_zero) spec_val = {sgn_md, 11'h7FF, 52'd0};
        else if (a_nan) spec_val = qa;
        else if (b_nan) spec_val = qb;
        else if (a_inf && b_inf) spec_val = vdw_pkg::QNAN_DEF;
        else if (a_inf) spec_val = {sgn_md, 11'h7FF, 52'd0};
        else if (b_inf || a_zero) spec_val = {sgn_md, 63'd0};
        else spec_hit = 1'b0;
      end
      default: spec_hit = 1'b0;
    endcase
  end

  // Multiplier step: one 27x27 partial product per cycle.
  logic [26:0]  mx_sel, my_sel;
  logic [53:0]  pp;
  logic [5:0]   pp_sh;
  logic [105:0] acc_nxt;

  always_comb begin
    mx_sel  = cnt_r[1] ? {1'b0, ma_r[52:27]} : ma_r[26:0];
    my_sel  = cnt_r[0] ? {1'b0, mb_r[52:27]} : mb_r[26:0];
    pp      = mx_sel * my_sel;
    pp_sh   = (cnt_r[1:0] == 2'd0) ? 6'd0 : ((cnt_r[1:0] == 2'd3) ? 6'd54 : 6'd27);
    acc_nxt = acc_r + ({52'd0, pp} << pp_sh);
  end

  // Divider step: one quotient bit per cycle.
  logic        q_bit;
  logic [54:0] rem_sub, rem_keep;

  always_comb begin
    q_bit    = rem_r >= {2'b00, mb_r};
    rem_sub  = rem_r - {2'b00, mb_r};
    rem_keep = q_bit ? rem_sub : rem_r;
  end

  // Alignment of the smaller addend, with its lost bits folded into bit 0.
  logic               a_big, far, lost;
  logic [52:0]        mx, my;
  logic signed [12:0] ex, dexp;
  logic               sx, sy;
  logic [63:0]        b0, bal;

  always_comb begin
    a_big = (ea_r > eb_r) || ((ea_r == eb_r) && (ma_r >= mb_r));
    mx    = a_big ? ma_r : mb_r;
    my    = a_big ? mb_r : ma_r;
    ex    = a_big ? ea_r : eb_r;
    sx    = a_big ? sa_r : sb_r;
    sy    = a_big ? sb_r : sa_r;
    dexp  = a_big ? (ea_r - eb_r) : (eb_r - ea_r);
    far   = dexp >= 13'sd64;
    b0    = {1'b0, my, 10'd0};
    lost  = |(b0 & ~({64{1'b1}} << dexp[5:0]));
    bal   = far ? 64'd1 : ((b0 >> dexp[5:0]) | {63'd0, lost});
  end

  logic [63:0] sum;
  always_comb begin
    sum = sub_r ? (sig_r - bsh_r) : (sig_r + bsh_r);
  end

  // Normalization moves one bit per cycle; rounding packs the result.
  logic signed [12:0] bias;
  logic               shl, shr, norm_done, rnd_inc;
  logic [10:0]        expf;
  logic [62:0]        packed_mag;
  logic [63:0]        round_val;

  always_comb begin
    bias       = e_r + 13'sd1023;
    shl        = !sig_r[63] && (bias > 13'sd1);
    shr        = bias < 13'sd1;
    norm_done  = (sig_r == 64'd0) || !(shl || shr);
    expf       = sig_r[63] ? bias[10:0] : 11'd0;
    rnd_inc    = sig_r[10] & ((|sig_r[9:0]) | st_r | sig_r[11]);
    packed_mag = {expf, sig_r[62:11]} + {62'd0, rnd_inc};
    if (sig_r == 64'd0) begin
      round_val = {sgn_r, 63'd0};
    end else if (bias >= 13'sd2047) begin
      round_val = {sgn_r, 11'h7FF, 52'd0};
    end else begin
      round_val = {sgn_r, packed_mag};
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vdw_pkg::F_IDLE:    if (req.start) state_nxt = spec_hit ? vdw_pkg::F_DONE
                                                             : vdw_pkg::F_PRENORM;
      vdw_pkg::F_PRENORM: begin
        if (ma_r[52] && mb_r[52]) begin
          unique case (op_r)
            vdw_pkg::FOP_MUL: state_nxt = vdw_pkg::F_MUL;
            vdw_pkg::FOP_DIV: state_nxt = vdw_pkg::F_DIV;
            default:          state_nxt = vdw_pkg::F_ALIGN;
          endcase
        end
      end
      vdw_pkg::F_MUL:   if (cnt_r[2]) state_nxt = vdw_pkg::F_NORM;
      vdw_pkg::F_DIV:   if (cnt_r[6]) state_nxt = vdw_pkg::F_NORM;
      vdw_pkg::F_ALIGN: state_nxt = vdw_pkg::F_ADD;
      vdw_pkg::F_ADD:   state_nxt = vdw_pkg::F_NORM;
      vdw_pkg::F_NORM:  if (norm_done) state_nxt = vdw_pkg::F_ROUND;
      vdw_pkg::F_ROUND: state_nxt = vdw_pkg::F_DONE;
      vdw_pkg::F_DONE:  state_nxt = vdw_pkg::F_IDLE;
      default:          state_nxt = vdw_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    rsp.done  = state_r == vdw_pkg::F_DONE;
    rsp.value = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vdw_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      vdw_pkg::F_IDLE: begin
        if (req.start) begin
          op_r  <= req.op;
          res_r <= spec_val;
          sa_r  <= req.a[63];
          sb_r  <= sb_eff;
          ea_r  <= a_e;
          eb_r  <= b_e;
          ma_r  <= a_m;
          mb_r  <= b_m;
        end
      end
      vdw_pkg::F_PRENORM: begin
        if (!ma_r[52]) begin
          ma_r <= {ma_r[51:0], 1'b0};
          ea_r <= ea_r - 13'sd1;
        end
        if (!mb_r[52]) begin
          mb_r <= {mb_r[51:0], 1'b0};
          eb_r <= eb_r - 13'sd1;
        end
        acc_r <= '0;
        cnt_r <= '0;
        sig_r <= '0;
        rem_r <= {2'b00, ma_r};
      end
      vdw_pkg::F_MUL: begin
        if (!cnt_r[2]) begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_r + 7'd1;
        end else begin
          sig_r <= acc_r[105:42];
          st_r  <= |acc_r[41:0];
          e_r   <= ea_r + eb_r + 13'sd1;
          sgn_r <= sa_r ^ sb_r;
        end
      end
      vdw_pkg::F_DIV: begin
        if (!cnt_r[6]) begin
          sig_r <= {sig_r[62:0], q_bit};
          rem_r <= {rem_keep[53:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
        end else begin
          st_r  <= |rem_r;
          e_r   <= ea_r - eb_r;
          sgn_r <= sa_r ^ sb_r;
        end
      end
      vdw_pkg::F_ALIGN: begin
        sig_r <= {1'b0, mx, 10'd0};
        bsh_r <= bal;
        e_r   <= ex + 13'sd1;
        sgn_r <= sx;
        sub_r <= sx ^ sy;
        st_r  <= 1'b0;
      end
      vdw_pkg::F_ADD: begin
        sig_r <= sum;
        // Exact cancellation gives positive zero.
        if (sum == 64'd0) sgn_r <= 1'b0;
      end
      vdw_pkg::F_NORM: begin
        if (sig_r != 64'd0) begin
          if (shl) begin
            sig_r <= {sig_r[62:0], 1'b0};
            e_r   <= e_r - 13'sd1;
          end else if (shr) begin
            st_r  <= st_r | sig_r[0];
            sig_r <= {1'b0, sig_r[63:1]};
            e_r   <= e_r + 13'sd1;
          end
        end
      end
      vdw_pkg::F_ROUND: res_r <= round_val;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/vdw_seq.sv =====
// Sequencer that walks the equation of state through the shared FP unit and
// holds the item, the intermediates and the result. Uses vdw_pkg and the
// channel interfaces.
`default_nettype none
module vdw_seq #(
  parameter int MAX_ITERATIONS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  vdw_in_if.sink            in_chan,
  vdw_out_if.source         out_chan,
  input  logic [63:0]       gas,
  input  logic [63:0]       cov,
  input  logic [63:0]       att,
  output vdw_pkg::fpu_req_t req,
  input  vdw_pkg::fpu_rsp_t rsp
);

  localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

  vdw_pkg::seq_st_t state_r, state_nxt;
  logic              issued_r, calc;
  logic [1:0]        mode_r;
  logic [63:0]       rho_r, t_r, p_r, rt_r, nu_r, x_r, y_r, value_r;
  logic [1:0]        status_r;
  logic [ITER_W-1:0] iter_r, iter_inc;
  logic              r_nan, le0, conv, last;

  always_comb begin
    r_nan    = (&rsp.value[62:52]) & (|rsp.value[51:0]);
    le0      = ~(|rsp.value[62:0]) | (rsp.value[63] & ~r_nan);
    // A NaN step counts as converged.
    conv     = r_nan | (rsp.value[62:0] <= vdw_pkg::DBL_TOL[62:0]);
    iter_inc = iter_r + ITER_W'(1);
    last     = iter_inc == ITER_W'(MAX_ITERATIONS);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vdw_pkg::S_IDLE: begin
        if (in_chan.valid) begin
          unique case (in_chan.mode)
            vdw_pkg::MODE_PRESSURE,
            vdw_pkg::MODE_TEMPERATURE: state_nxt = vdw_pkg::S_M_RECIP;
            vdw_pkg::MODE_DENSITY:     state_nxt = vdw_pkg::S_D_RT;
            default:                   state_nxt = vdw_pkg::S_OUT;
          endcase
        end
      end
      vdw_pkg::S_OUT: if (out_chan.ready) state_nxt = vdw_pkg::S_IDLE;
      default: begin
        if (rsp.done) begin
          unique case (state_r)
            vdw_pkg::S_M_RECIP: state_nxt = vdw_pkg::S_M_NU1;
            vdw_pkg::S_M_NU1: begin
              priority if (le0) state_nxt = vdw_pkg::S_OUT;
              else if (mode_r == vdw_pkg::MODE_PRESSURE) state_nxt = vdw_pkg::S_P_RT;
              else state_nxt = vdw_pkg::S_T_AR;
            end
            vdw_pkg::S_P_RT:  state_nxt = vdw_pkg::S_P_DIV;
            vdw_pkg::S_P_DIV: state_nxt = vdw_pkg::S_P_AR;
            vdw_pkg::S_P_AR:  state_nxt = vdw_pkg::S_P_ARR;
            vdw_pkg::S_P_ARR: state_nxt = vdw_pkg::S_P_SUB;
            vdw_pkg::S_T_AR:  state_nxt = vdw_pkg::S_T_ARR;
            vdw_pkg::S_T_ARR: state_nxt = vdw_pkg::S_T_ADD;
            vdw_pkg::S_T_ADD: state_nxt = vdw_pkg::S_T_MUL;
            vdw_pkg::S_T_MUL: state_nxt = vdw_pkg::S_T_DIV;
            vdw_pkg::S_D_RT:  state_nxt = vdw_pkg::S_D_Q;
            vdw_pkg::S_D_Q:   state_nxt = vdw_pkg::S_D_NU0;
            vdw_pkg::S_D_NU0: state_nxt = vdw_pkg::S_D_SQ;
            vdw_pkg::S_D_SQ:  state_nxt = vdw_pkg::S_D_AW;
            vdw_pkg::S_D_AW:  state_nxt = vdw_pkg::S_D_PS;
            vdw_pkg::S_D_PS:  state_nxt = vdw_pkg::S_D_U;
            vdw_pkg::S_D_U:   state_nxt = vdw_pkg::S_D_NN;
            vdw_pkg::S_D_NN:  state_nxt = vdw_pkg::S_D_DIF;
            vdw_pkg::S_D_DIF: state_nxt = (conv || last) ? vdw_pkg::S_D_INV
                                                         : vdw_pkg::S_D_SQ;
            default:          state_nxt = vdw_pkg::S_OUT;
          endcase
        end
      end
    endcase
  end

  // Operation and operands issued to the FP unit in each step.
  always_comb begin
    calc   = 1'b1;
    req.op = vdw_pkg::FOP_ADD;
    req.a  = '0;
    req.b  = '0;
    unique case (state_r)
      vdw_pkg::S_M_RECIP: begin req.op = vdw_pkg::FOP_DIV; req.a = vdw_pkg::DBL_ONE; req.b = rho_r; end
      vdw_pkg::S_M_NU1:   begin req.op = vdw_pkg::FOP_SUB; req.a = x_r;  req.b = cov;   end
      vdw_pkg::S_P_RT:    begin req.op = vdw_pkg::FOP_MUL; req.a = gas;  req.b = t_r;   end
      vdw_pkg::S_P_DIV:   begin req.op = vdw_pkg::FOP_DIV; req.a = y_r;  req.b = x_r;   end
      vdw_pkg::S_P_AR:    begin req.op = vdw_pkg::FOP_MUL; req.a = att;  req.b = rho_r; end
      vdw_pkg::S_P_ARR:   begin req.op = vdw_pkg::FOP_MUL; req.a = rt_r; req.b = rho_r; end
      vdw_pkg::S_P_SUB:   begin req.op = vdw_pkg::FOP_SUB; req.a = y_r;  req.b = rt_r;  end
      vdw_pkg::S_T_AR:    begin req.op = vdw_pkg::FOP_MUL; req.a = att;  req.b = rho_r; end
      vdw_pkg::S_T_ARR:   begin req.op = vdw_pkg::FOP_MUL; req.a = y_r;  req.b = rho_r; end
      vdw_pkg::S_T_ADD:   begin req.op = vdw_pkg::FOP_ADD; req.a = p_r;  req.b = y_r;   end
      vdw_pkg::S_T_MUL:   begin req.op = vdw_pkg::FOP_MUL; req.a = y_r;  req.b = x_r;   end
      vdw_pkg::S_T_DIV:   begin req.op = vdw_pkg::FOP_DIV; req.a = y_r;  req.b = gas;   end
      vdw_pkg::S_D_RT:    begin req.op = vdw_pkg::FOP_MUL; req.a = gas;  req.b = t_r;   end
      vdw_pkg::S_D_Q:     begin req.op = vdw_pkg::FOP_DIV; req.a = rt_r; req.b = p_r;   end
      vdw_pkg::S_D_NU0:   begin req.op = vdw_pkg::FOP_ADD; req.a = y_r;  req.b = cov;   end
      vdw_pkg::S_D_SQ:    begin req.op = vdw_pkg::FOP_MUL; req.a = nu_r; req.b = nu_r;  end
      vdw_pkg::S_D_AW:    begin req.op = vdw_pkg::FOP_DIV; req.a = att;  req.b = y_r;   end
      vdw_pkg::S_D_PS:    begin req.op = vdw_pkg::FOP_ADD; req.a = p_r;  req.b = y_r;   end
      vdw_pkg::S_D_U:     begin req.op = vdw_pkg::FOP_DIV; req.a = rt_r; req.b = y_r;   end
      vdw_pkg::S_D_NN:    begin req.op = vdw_pkg::FOP_ADD; req.a = y_r;  req.b = cov;   end
      vdw_pkg::S_D_DIF:   begin req.op = vdw_pkg::FOP_SUB; req.a = nu_r; req.b = x_r;   end
      vdw_pkg::S_D_INV:   begin req.op = vdw_pkg::FOP_DIV; req.a = vdw_pkg::DBL_ONE; req.b = nu_r; end
      default:            calc = 1'b0;
    endcase
    req.start         = calc & ~issued_r;
    in_chan.ready     = state_r == vdw_pkg::S_IDLE;
    out_chan.valid    = state_r == vdw_pkg::S_OUT;
    out_chan.value_out = value_r;
    out_chan.status   = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= vdw_pkg::S_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (req.start) begin
        issued_r <= 1'b1;
      end else if (rsp.done) begin
        issued_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == vdw_pkg::S_IDLE) && in_chan.valid) begin
      mode_r   <= in_chan.mode;
      rho_r    <= in_chan.density_in;
      t_r      <= in_chan.temperature_in;
      p_r      <= in_chan.pressure_in;
      value_r  <= '0;
      status_r <= vdw_pkg::STATUS_OK;
    end else if (rsp.done) begin
      unique case (state_r)
        vdw_pkg::S_M_RECIP: x_r <= rsp.value;
        vdw_pkg::S_M_NU1: begin
          x_r <= rsp.value;
          if (le0) status_r <= vdw_pkg::STATUS_VOLUME;
        end
        vdw_pkg::S_P_RT, vdw_pkg::S_P_DIV, vdw_pkg::S_T_AR, vdw_pkg::S_T_ARR,
        vdw_pkg::S_T_ADD, vdw_pkg::S_T_MUL, vdw_pkg::S_D_Q, vdw_pkg::S_D_SQ,
        vdw_pkg::S_D_AW, vdw_pkg::S_D_PS, vdw_pkg::S_D_U: y_r <= rsp.value;
        vdw_pkg::S_P_AR, vdw_pkg::S_P_ARR, vdw_pkg::S_D_RT: rt_r <= rsp.value;
        vdw_pkg::S_D_NU0: begin
          nu_r   <= rsp.value;
          iter_r <= '0;
        end
        vdw_pkg::S_D_NN: x_r <= rsp.value;
        vdw_pkg::S_D_DIF: begin
          nu_r   <= x_r;
          iter_r <= iter_inc;
          if (!conv && last) status_r <= vdw_pkg::STATUS_ITER_LIMIT;
        end
        vdw_pkg::S_P_SUB, vdw_pkg::S_T_DIV, vdw_pkg::S_D_INV: value_r <= rsp.value;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/van_der_waals_state_eval_top.sv =====
// Top level of the van der Waals state evaluator: configuration registers,
// sequencer and shared FP unit. Uses vdw_pkg, the channel interfaces,
// vdw_seq and vdw_fpu.
//
// The block evaluates the van der Waals equation of state in IEEE double
// precision, one item at a time: it takes an input beat, runs every
// operation through a single shared add/multiply/divide unit, and holds the
// result beat until it is taken; no new item is accepted meanwhile. The
// shared unit sets the pace: a divide forms one quotient bit per cycle, a
// multiply sums four 27x27 partial products, and an add or subtract
// normalizes its result one bit per cycle. Operations settled as NaN,
// infinity or zero skip the datapath, while subnormal operands or results
// that underflow add extra shifting. Pressure and temperature items end
// early when the volume test fails after the first two operations; a
// density item runs at most MAX_ITERATIONS fixed-point iterations.
`default_nettype none
module van_der_waals_state_eval_top #(
  parameter int MAX_ITERATIONS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  vdw_cfg_if.sink   cfg_chan,
  vdw_in_if.sink    in_chan,
  vdw_out_if.source out_chan
);

  logic [63:0]       gas_r, cov_r, att_r;
  vdw_pkg::fpu_req_t fpu_req;
  vdw_pkg::fpu_rsp_t fpu_rsp;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gas_r <= '0;
      cov_r <= '0;
      att_r <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        vdw_pkg::CFG_GAS:   gas_r <= cfg_chan.data;
        vdw_pkg::CFG_COVOL: cov_r <= cfg_chan.data;
        vdw_pkg::CFG_ATTR:  att_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  vdw_seq #(
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .gas      (gas_r),
    .cov      (cov_r),
    .att      (att_r),
    .req      (fpu_req),
    .rsp      (fpu_rsp)
  );

  vdw_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fpu_req),
    .rsp   (fpu_rsp)
  );

endmodule
`default_nettype wire
